// ===== rtl/core/uafb_pkg.sv =====
// ----------------------------------------------------------------------------
// uafb_pkg
// Shared types for the serial-link to memory debug bridge.
// ----------------------------------------------------------------------------
package uafb_pkg;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // Frame positions that mean something; everything else restarts a frame
  localparam logic [2:0] POS_ADDR1 = 3'd1;
  localparam logic [2:0] POS_ADDR2 = 3'd2;
  localparam logic [2:0] POS_ADDR3 = 3'd3;
  localparam logic [2:0] POS_LAST  = 3'd4;
  localparam logic [2:0] POS_WDATA = 3'd5;

  localparam logic [1:0] TX_LAST_BEAT = 2'd3;

  // One decoded result bundle: a reply word (four link bytes) or one request
  typedef struct packed {
    logic        vld;
    kind_e       kind;
    logic [31:0] data;   // reply word or word-aligned address
    logic [7:0]  wbyte;
    logic [3:0]  mask;
  } res_t;

endpackage

// ===== rtl/core/uafb_frame.sv =====
// ----------------------------------------------------------------------------
// uafb_frame
// Frame assembler: tracks the byte position of the access frame and decides
// which result bundle, if any, an accepted input item produces.
// ----------------------------------------------------------------------------
module uafb_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               cmd_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        read_word_i,
  output uafb_pkg::res_t     res_o
);

  logic [2:0]  pos_q, pos_d;
  logic [31:0] addr_q, addr_d;
  logic        wflag_q, wflag_d;
  logic [3:0]  mask_q, mask_d;
  logic [2:0]  data_q, data_d;
  logic        rd_pend_q, rd_pend_d;

  logic [31:0] addr_bit0;

  assign addr_bit0 = {addr_q[30:0], rx_byte_i[7]};

  always_comb begin
    pos_d     = pos_q;
    addr_d    = addr_q;
    wflag_d   = wflag_q;
    mask_d    = mask_q;
    data_d    = data_q;
    rd_pend_d = rd_pend_q;

    res_o       = '0;
    res_o.kind  = uafb_pkg::KIND_TX;

    if (cmd_i) begin
      // read data only answers a pending read
      if (rd_pend_q) begin
        rd_pend_d  = 1'b0;
        res_o.vld  = 1'b1;
        res_o.kind = uafb_pkg::KIND_TX;
        res_o.data = read_word_i;
      end
    end else begin
      case (pos_q)
        uafb_pkg::POS_ADDR1, uafb_pkg::POS_ADDR2, uafb_pkg::POS_ADDR3: begin
          addr_d = {addr_q[23:0], rx_byte_i};
          pos_d  = pos_q + 3'd1;
        end
        uafb_pkg::POS_LAST: begin
          addr_d = addr_bit0;
          if (!wflag_q) begin
            pos_d      = '0;
            rd_pend_d  = 1'b1;
            res_o.vld  = 1'b1;
            res_o.kind = uafb_pkg::KIND_READ;
            res_o.data = {addr_bit0[31:2], 2'b00};
          end else begin
            mask_d = rx_byte_i[6:3];
            data_d = rx_byte_i[2:0];
            pos_d  = uafb_pkg::POS_WDATA;
          end
        end
        uafb_pkg::POS_WDATA: begin
          pos_d       = '0;
          res_o.vld   = 1'b1;
          res_o.kind  = uafb_pkg::KIND_WRITE;
          res_o.data  = {addr_q[31:2], 2'b00};
          res_o.wbyte = {data_q, rx_byte_i[7:3]};
          res_o.mask  = mask_q;
        end
        default: begin
          // start of frame (also recovers from unused positions)
          wflag_d = rx_byte_i[7];
          addr_d  = {25'd0, rx_byte_i[6:0]};
          pos_d   = uafb_pkg::POS_ADDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      addr_q    <= '0;
      wflag_q   <= 1'b0;
      mask_q    <= '0;
      data_q    <= '0;
      rd_pend_q <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      addr_q    <= addr_d;
      wflag_q   <= wflag_d;
      mask_q    <= mask_d;
      data_q    <= data_d;
      rd_pend_q <= rd_pend_d;
    end
  end

endmodule

// ===== rtl/core/uart_frame_memory_bridge_top.sv =====
// ----------------------------------------------------------------------------
// uart_frame_memory_bridge_top
// Serial-link to memory debug bridge: assembles access frames from link
// bytes, issues read and masked write requests, returns read data as bytes.
// ----------------------------------------------------------------------------
// Output is registered. Throughput: one input item per cycle unless the
// receiver stalls a held result; a read-data item occupies the output
// register for four transfers (one per reply byte), which holds off input.
// Reset: asynchronous, active low; frame position, pending read and output
// valid are cleared, so the bridge starts waiting for byte 1 of a frame.
module uart_frame_memory_bridge_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] read_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] mem_addr_o,
  output logic [7:0]  write_byte_o,
  output logic [3:0]  byte_mask_o,
  output logic        last_o
);

  uafb_pkg::res_t  res;
  logic            accept;
  logic            out_xfer;
  logic            last_beat;
  logic            free;

  logic            vld_q;
  uafb_pkg::kind_e kind_q;
  logic [31:0]     data_q;
  logic [7:0]      wbyte_q;
  logic [3:0]      mask_q;
  logic [1:0]      beat_q;

  uafb_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .read_word_i (read_word_i),
    .res_o       (res)
  );

  assign last_beat = (kind_q != uafb_pkg::KIND_TX) || (beat_q == uafb_pkg::TX_LAST_BEAT);
  assign out_xfer  = vld_q && out_ready_i;
  assign free      = !vld_q || (out_xfer && last_beat);
  assign in_ready_o = free;
  assign accept    = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= '0;
    end else if (accept && res.vld) begin
      vld_q  <= 1'b1;
      beat_q <= '0;
    end else if (out_xfer) begin
      if (last_beat) begin
        vld_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  // payload: reply word shifts down one byte per transfer
  always_ff @(posedge clk_i) begin
    if (accept && res.vld) begin
      kind_q  <= res.kind;
      data_q  <= res.data;
      wbyte_q <= res.wbyte;
      mask_q  <= res.mask;
    end else if (out_xfer && !last_beat) begin
      data_q <= {8'd0, data_q[31:8]};
    end
  end

  assign out_valid_o  = vld_q;
  assign kind_o       = kind_q;
  assign tx_byte_o    = (kind_q == uafb_pkg::KIND_TX) ? data_q[7:0] : 8'd0;
  assign mem_addr_o   = (kind_q == uafb_pkg::KIND_TX) ? 32'd0 : data_q;
  assign write_byte_o = wbyte_q;
  assign byte_mask_o  = mask_q;
  assign last_o       = last_beat;

endmodule

// ===== tb/uart_frame_memory_bridge_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_memory_bridge_top_tb
// Self-checking bench for the serial-link to memory debug bridge. Link bytes
// and read-data words go in over a valid/ready channel. A frame decoder in the
// bench tracks the bridge state and queues the read requests, write requests
// and reply bytes that each transfer should give, and every output transfer
// is checked in order, field by field. Directed frames at the field limits
// come first, then random frames with noise under several idling mixes and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module uart_frame_memory_bridge_top_tb;

  localparam logic [2:0] POS_START = 3'd0;

  typedef struct {
    uafb_pkg::kind_e kind;
    logic [7:0]      tx;
    logic [31:0]     addr;
    logic [7:0]      wbyte;
    logic [3:0]      mask;
    logic            last;
  } bridge_op_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        cmd_i       = 1'b0;
  logic [7:0]  rx_byte_i   = 8'd0;
  logic [31:0] read_word_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [31:0] mem_addr_o;
  logic [7:0]  write_byte_o;
  logic [3:0]  byte_mask_o;
  logic        last_o;

  uart_frame_memory_bridge_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .read_word_i  (read_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .mem_addr_o   (mem_addr_o),
    .write_byte_o (write_byte_o),
    .byte_mask_o  (byte_mask_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Frame decoder state, mirrors the bridge
  logic [2:0]  frame_pos;
  logic [31:0] addr_acc;
  logic        wr_flag;
  logic [3:0]  mask_q;
  logic [7:0]  data_q;
  logic        read_wait;

  bridge_op_t  bridge_ops_q[$];

  int n_errors     = 0;
  int n_taken      = 0;
  int n_ignored    = 0;
  int n_reads      = 0;
  int n_writes     = 0;
  int n_reply      = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit sink_hold    = 1'b0;

  function automatic void append_op(bridge_op_t op);
    bridge_ops_q = {bridge_ops_q, op};
  endfunction

  function automatic void decode_link_item(logic c, logic [7:0] b, logic [31:0] w);
    bridge_op_t op;
    if (c) begin
      // read data with nothing outstanding is dropped
      if (!read_wait) begin
        n_ignored++;
        return;
      end
      read_wait = 1'b0;
      n_taken++;
      for (int k = 0; k < 4; k++) begin
        op = '{uafb_pkg::KIND_TX, w[8*k +: 8], 32'd0, 8'd0, 4'd0, (k == 3)};
        append_op(op);
      end
      return;
    end
    n_taken++;
    case (frame_pos)
      uafb_pkg::POS_ADDR1, uafb_pkg::POS_ADDR2, uafb_pkg::POS_ADDR3: begin
        addr_acc  = {addr_acc[23:0], b};
        frame_pos = frame_pos + 3'd1;
      end
      uafb_pkg::POS_LAST: begin
        addr_acc = {addr_acc[30:0], b[7]};
        if (!wr_flag) begin
          frame_pos = POS_START;
          read_wait = 1'b1;
          op = '{uafb_pkg::KIND_READ, 8'd0, {addr_acc[31:2], 2'b00}, 8'd0, 4'd0, 1'b1};
          append_op(op);
        end else begin
          mask_q    = b[6:3];
          data_q    = {5'd0, b[2:0]};
          frame_pos = uafb_pkg::POS_WDATA;
        end
      end
      uafb_pkg::POS_WDATA: begin
        data_q    = {data_q[2:0], b[7:3]};
        frame_pos = POS_START;
        op = '{uafb_pkg::KIND_WRITE, 8'd0, {addr_acc[31:2], 2'b00}, data_q, mask_q, 1'b1};
        append_op(op);
      end
      default: begin
        wr_flag   = b[7];
        addr_acc  = {25'd0, b[6:0]};
        frame_pos = uafb_pkg::POS_ADDR1;
      end
    endcase
  endfunction

  // Receiver: random stalls, or held off entirely
  always @(negedge clk_i) begin
    out_ready_i <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    bridge_op_t op;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bridge_ops_q.size() == 0) begin
        $display("%0t: unexpected result, kind 0x%0h addr 0x%0h tx 0x%0h", $time, kind_o,
                 mem_addr_o, tx_byte_o);
        n_errors++;
      end else begin
        op = bridge_ops_q.pop_front();
        report_field("kind", 32'(op.kind), 32'(kind_o));
        report_field("tx_byte", 32'(op.tx), 32'(tx_byte_o));
        report_field("mem_addr", op.addr, mem_addr_o);
        report_field("write_byte", 32'(op.wbyte), 32'(write_byte_o));
        report_field("byte_mask", 32'(op.mask), 32'(byte_mask_o));
        report_field("last", 32'(op.last), 32'(last_o));
        case (op.kind)
          uafb_pkg::KIND_READ:  n_reads++;
          uafb_pkg::KIND_WRITE: n_writes++;
          default:              n_reply++;
        endcase
      end
    end
  end

  // One input transfer; valid is only dropped when a gap is taken
  task automatic send_item(logic c, logic [7:0] b, logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    rx_byte_i   <= b;
    read_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    decode_link_item(c, b, w);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b, $urandom);
  endtask

  task automatic send_word(logic [31:0] w);
    send_item(1'b1, 8'($urandom), w);
  endtask

  task automatic read_frame(logic [31:0] a);
    send_byte({1'b0, a[31:25]});
    send_byte(a[24:17]);
    send_byte(a[16:9]);
    send_byte(a[8:1]);
    send_byte({a[0], 7'($urandom)});
  endtask

  task automatic write_frame(logic [31:0] a, logic [3:0] m, logic [7:0] d);
    send_byte({1'b1, a[31:25]});
    send_byte(a[24:17]);
    send_byte(a[16:9]);
    send_byte(a[8:1]);
    send_byte({a[0], m, d[7:5]});
    send_byte({d[4:0], 3'($urandom)});
  endtask

  // Sender goes quiet, then wait for every expected result
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bridge_ops_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_stray_read_data();
    send_word(32'hA5A5_5A5A);
  endtask

  task automatic test_field_extremes();
    read_frame(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    write_frame(32'hFFFF_FFFF, 4'h0, 8'hFF);
  endtask

  // Link bytes keep framing while a read is outstanding
  task automatic test_read_pending_overlap();
    read_frame(32'h0000_0000);
    write_frame(32'h0000_0002, 4'hF, 8'h00);
    send_word(32'h0000_0000);
  endtask

  task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
    int start;
    int sel;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = n_taken;
    while (n_taken - start < n_items) begin
      sel = $urandom_range(99);
      // noise may leave a frame half done: random bytes finish it off
      if (sel < 75) begin
        while (frame_pos != POS_START) send_byte(8'($urandom));
      end
      if (sel < 40) begin
        read_frame(pick_addr());
        if ($urandom_range(3) != 0) send_word($urandom);
      end else if (sel < 75) begin
        write_frame(pick_addr(), 4'($urandom), 8'($urandom));
      end else if (sel < 88) begin
        send_word($urandom);
      end else begin
        send_byte(8'($urandom));
      end
    end
    wait_drain();
  endtask

  // Receiver held off so read frames stall behind the held output, then the sender waits for all replies
  task automatic test_backpressure_fill();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        sink_hold = 1'b0;
      end
    join_none
    repeat (3) begin
      read_frame($urandom);
      send_word($urandom);
    end
    write_frame($urandom, 4'($urandom), 8'($urandom));
    wait_drain();
  endtask

  initial begin
    frame_pos = POS_START;
    addr_acc  = 32'd0;
    wr_flag   = 1'b0;
    mask_q    = 4'd0;
    data_q    = 8'd0;
    read_wait = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_stray_read_data();
    test_field_extremes();
    test_read_pending_overlap();
    wait_drain();
    test_random_traffic(0, 0, 72);
    test_random_traffic(80, 0, 72);
    test_random_traffic(0, 80, 72);
    test_random_traffic(24, 24, 72);
    test_backpressure_fill();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk_i);

    if (bridge_ops_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, bridge_ops_q.size());
      n_errors++;
    end
    $display("Sent %0d effective transfers (%0d stray read words dropped); checked %0d reads,",
             n_taken, n_ignored, n_reads);
    $display("%0d writes and %0d reply bytes across idle, stall and hold-off mixes.",
             n_writes, n_reply);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the bridge");
    $display("== FAIL ==");
    $finish;
  end

endmodule
